// ===== design/sem_pkg.sv =====
// Shared constants and types for the RGB Sobel edge magnitude block.
// No dependencies; the line store, lane and top level refer to it by scoped names.
package sem_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int CFG_DW  = 12;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WUSED_W = $clog2(MAX_WIDTH + 1);
  localparam int HUSED_W = $clog2(MAX_HEIGHT + 1);
  localparam int POS_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CFG_DW-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_DW-1:0] RESET_HEIGHT = 12'd480;

  // Largest radicand whose rounded root still fits in eight bits.
  localparam logic [20:0] ROOT_LIMIT = 21'd65280;
  localparam logic [7:0]  EDGE_MAX   = 8'd255;

  typedef logic [7:0]  chan_t;
  typedef logic [23:0] pix_t;
  typedef logic [8:0][7:0] taps_t;

endpackage

// ===== design/sem_in_if.sv =====
// Input stream channel: valid/ready handshake with command and RGB pixel.
// Depends on nothing.
interface sem_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, command, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

// ===== design/sem_out_if.sv =====
// Result stream channel: valid/ready handshake with red, green and blue edge magnitudes and a frame-end flag.
// Depends on nothing.
interface sem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_edge;
  logic [7:0] green_edge;
  logic [7:0] blue_edge;
  logic       frame_last;

  modport source (output valid, red_edge, green_edge, blue_edge, frame_last, input ready);
  modport sink   (input valid, red_edge, green_edge, blue_edge, frame_last, output ready);
endinterface

// ===== design/sem_line_buf.sv =====
// Two-row line store, both rows side by side in one word per column.
// Depends on sem_pkg for the column count and address width.
module sem_line_buf (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [sem_pkg::COL_W-1:0] rd_addr,
  output logic [47:0]              rd_data,
  input  logic                     wr_en,
  input  logic [sem_pkg::COL_W-1:0] wr_addr,
  input  logic [47:0]              wr_data
);

  logic [47:0] mem [sem_pkg::MAX_WIDTH];
  logic [47:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/sem_lane.sv =====
// One color lane: Sobel gradients, squared magnitude and an iterative
// rounded square root, one result bit per cycle. Depends on sem_pkg.
module sem_lane (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [8:0][7:0]       taps,
  output logic                  done,
  output logic [7:0]            edge_mag
);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_SQ   = 3'd1;
  localparam logic [2:0] P_SUM  = 3'd2;
  localparam logic [2:0] P_ITER = 3'd3;
  localparam logic [2:0] P_RND  = 3'd4;

  logic [2:0]         phase_r, phase_nxt;
  logic signed [11:0] gx_r, gy_r, gx_nxt, gy_nxt;
  logic [19:0]        sqx_r, sqy_r;
  logic [15:0]        n_r;
  logic               big_r;
  logic [7:0]         root_r, bit_r;
  logic [7:0]         edge_r;
  logic               done_r;

  logic signed [11:0] t [9];
  logic [20:0]        sum;
  logic [7:0]         trial;
  logic [15:0]        trial_sq;
  logic [16:0]        rr;
  logic [8:0]         root_up;
  logic signed [23:0] px, py;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      t[i] = $signed({4'b0, taps[i]});
    end
    gx_nxt = t[2] + (t[5] <<< 1) + t[8] - t[0] - (t[3] <<< 1) - t[6];
    gy_nxt = t[6] + (t[7] <<< 1) + t[8] - t[0] - (t[1] <<< 1) - t[2];
    px       = gx_r * gx_r;
    py       = gy_r * gy_r;
    sum      = {1'b0, sqx_r} + {1'b0, sqy_r};
    trial    = root_r | bit_r;
    trial_sq = {8'b0, trial} * {8'b0, trial};
    rr       = {9'b0, root_r} * {9'b0, root_r} + {9'b0, root_r};
    root_up  = {1'b0, root_r} + 9'd1;
  end

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      P_IDLE:  if (start) phase_nxt = P_SQ;
      P_SQ:    phase_nxt = P_SUM;
      P_SUM:   phase_nxt = P_ITER;
      P_ITER:  if (bit_r[0]) phase_nxt = P_RND;
      P_RND:   phase_nxt = P_IDLE;
      default: phase_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= (phase_r == P_RND);
    end
  end

  always_ff @(posedge clk) begin
    case (phase_r)
      P_IDLE: begin
        if (start) begin
          gx_r <= gx_nxt;
          gy_r <= gy_nxt;
        end
      end
      P_SQ: begin
        sqx_r <= px[19:0];
        sqy_r <= py[19:0];
      end
      P_SUM: begin
        big_r  <= (sum > sem_pkg::ROOT_LIMIT);
        n_r    <= sum[15:0];
        root_r <= 8'd0;
        bit_r  <= 8'h80;
      end
      P_ITER: begin
        if (trial_sq <= n_r) begin
          root_r <= trial;
        end
        bit_r <= bit_r >> 1;
      end
      P_RND: begin
        if (big_r) begin
          edge_r <= sem_pkg::EDGE_MAX;
        end else if ({1'b0, n_r} > rr) begin
          edge_r <= root_up[8] ? sem_pkg::EDGE_MAX : root_up[7:0];
        end else begin
          edge_r <= root_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign done     = done_r;
  assign edge_mag = edge_r;

endmodule

// ===== design/sobel_edge_magnitude_rgb.sv =====
// Streaming 3x3 Sobel edge magnitude on RGB pixels, one lane per channel.
// Depends on sem_pkg, sem_in_if, sem_out_if, sem_line_buf and sem_lane.
//
// Pixels of a frame arrive in raster order; the result for a pixel leaves
// on the transfer that carries the stream position width+1 later, and drain
// commands supply the positions past the frame end. Neighbors outside the
// image count as zero. Each accepted item passes a line-store read, and
// each but an in-frame drain a window update; one that yields a result
// then passes a tap step and the lanes' gradient, square and 8-step square
// root sequence. No new item is accepted before the current one is through.
// An input transfer may happen while a finished result still waits in the
// output register. A write to either size register restarts the stream.
module sobel_edge_magnitude_rgb (
  input  logic                        clk,
  input  logic                        rst_n,
  sem_in_if.sink                      in_ch,
  sem_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sem_pkg::CFG_DW-1:0]  cfg_data
);

  localparam int COL_W   = sem_pkg::COL_W;
  localparam int ROW_W   = sem_pkg::ROW_W;
  localparam int WUSED_W = sem_pkg::WUSED_W;
  localparam int HUSED_W = sem_pkg::HUSED_W;
  localparam int POS_W   = sem_pkg::POS_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FEED = 3'd1;
  localparam logic [2:0] S_TAP  = 3'd2;
  localparam logic [2:0] S_LANE = 3'd3;
  localparam logic [2:0] S_HOLD = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [sem_pkg::CFG_DW-1:0] width_r, height_r;
  logic [WUSED_W-1:0] w_used;
  logic [HUSED_W-1:0] h_used;
  logic [POS_W-1:0]   total;

  logic [POS_W-1:0] in_pos_r, in_pos_nxt, out_pos_r, out_pos_nxt;
  logic [COL_W-1:0] feed_col_r, feed_col_nxt, res_col_r, res_col_nxt;
  logic [ROW_W-1:0] res_row_r, res_row_nxt;
  sem_pkg::pix_t    win_r [9];
  sem_pkg::pix_t    win_nxt [9];
  sem_pkg::pix_t    pix_r;
  logic             feed_r;

  logic             accept, feed_ok, in_frame, lane_start, load, out_xfer, last;
  logic [47:0]      rd_data;
  logic [2:0]       lane_done;
  logic [7:0]       lane_edge [3];
  sem_pkg::taps_t   taps [3];
  logic [8:0]       tap_ok;
  logic [WUSED_W:0] col_cnt;

  logic             out_valid_r;
  logic [7:0]       red_r, green_r, blue_r;
  logic             last_r;

  always_comb begin
    if (width_r == '0) begin
      w_used = WUSED_W'(1);
    end else if ({1'b0, width_r} > (sem_pkg::CFG_DW + 1)'(sem_pkg::MAX_WIDTH)) begin
      w_used = WUSED_W'(sem_pkg::MAX_WIDTH);
    end else begin
      w_used = WUSED_W'(width_r);
    end
    if (height_r == '0) begin
      h_used = HUSED_W'(1);
    end else if ({1'b0, height_r} > (sem_pkg::CFG_DW + 1)'(sem_pkg::MAX_HEIGHT)) begin
      h_used = HUSED_W'(sem_pkg::MAX_HEIGHT);
    end else begin
      h_used = HUSED_W'(height_r);
    end
    total = POS_W'(w_used) * POS_W'(h_used);
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_frame    = (in_pos_r < total);
  assign feed_ok     = !in_frame || (in_ch.command == sem_pkg::CMD_PIXEL);
  assign out_xfer    = out_valid_r && out_ch.ready;
  assign load        = ((state_r == S_LANE && lane_done[0]) || state_r == S_HOLD)
                       && (!out_valid_r || out_ch.ready);
  assign last        = (out_pos_r == total - POS_W'(1));
  assign lane_start  = (state_r == S_TAP);
  assign col_cnt     = {1'b0, WUSED_W'(feed_col_r)} + (WUSED_W + 1)'(1);

  sem_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (feed_col_r),
    .rd_data (rd_data),
    .wr_en   (state_r == S_FEED && feed_r),
    .wr_addr (feed_col_r),
    .wr_data ({rd_data[23:0], pix_r})
  );

  // Border mask: taps that fall outside the image read as zero.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      tap_ok[i] = 1'b1;
      if (i < 3 && res_row_r == '0) tap_ok[i] = 1'b0;
      if (i >= 6 && ({1'b0, HUSED_W'(res_row_r)} + (HUSED_W + 1)'(1)) >= {1'b0, h_used})
        tap_ok[i] = 1'b0;
      if (i % 3 == 0 && res_col_r == '0) tap_ok[i] = 1'b0;
      if (i % 3 == 2 && ({1'b0, WUSED_W'(res_col_r)} + (WUSED_W + 1)'(1)) >= {1'b0, w_used})
        tap_ok[i] = 1'b0;
    end
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 9; i++) begin
        taps[c][i] = tap_ok[i] ? win_r[i][23-8*c -: 8] : 8'd0;
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    sem_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (lane_start),
      .taps     (taps[c]),
      .done     (lane_done[c]),
      .edge_mag (lane_edge[c])
    );
  end

  always_comb begin
    state_nxt    = state_r;
    in_pos_nxt   = in_pos_r;
    out_pos_nxt  = out_pos_r;
    feed_col_nxt = feed_col_r;
    res_col_nxt  = res_col_r;
    res_row_nxt  = res_row_r;
    for (int i = 0; i < 9; i++) win_nxt[i] = win_r[i];

    case (state_r)
      S_IDLE: if (accept) state_nxt = S_FEED;
      S_FEED: begin
        if (!feed_r) begin
          state_nxt = S_IDLE;
        end else begin
          for (int r = 0; r < 3; r++) begin
            win_nxt[3*r]   = win_r[3*r+1];
            win_nxt[3*r+1] = win_r[3*r+2];
          end
          win_nxt[2] = rd_data[47:24];
          win_nxt[5] = rd_data[23:0];
          win_nxt[8] = pix_r;
          feed_col_nxt = (col_cnt >= {1'b0, w_used}) ? '0 : col_cnt[COL_W-1:0];
          in_pos_nxt   = in_pos_r + POS_W'(1);
          state_nxt = (in_pos_nxt < POS_W'(w_used) + POS_W'(2)) ? S_IDLE : S_TAP;
        end
      end
      S_TAP:  state_nxt = S_LANE;
      S_LANE: if (lane_done[0]) state_nxt = load ? S_IDLE : S_HOLD;
      S_HOLD: if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase

    if (load) begin
      if (last) begin
        in_pos_nxt   = '0;
        out_pos_nxt  = '0;
        feed_col_nxt = '0;
        res_col_nxt  = '0;
        res_row_nxt  = '0;
        for (int i = 0; i < 9; i++) win_nxt[i] = '0;
      end else begin
        out_pos_nxt = out_pos_r + POS_W'(1);
        if ({1'b0, WUSED_W'(res_col_r)} + (WUSED_W + 1)'(1) >= {1'b0, w_used}) begin
          res_col_nxt = '0;
          res_row_nxt = res_row_r + ROW_W'(1);
        end else begin
          res_col_nxt = res_col_r + COL_W'(1);
        end
      end
    end

    if (cfg_we) begin
      in_pos_nxt   = '0;
      out_pos_nxt  = '0;
      feed_col_nxt = '0;
      res_col_nxt  = '0;
      res_row_nxt  = '0;
      for (int i = 0; i < 9; i++) win_nxt[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= sem_pkg::RESET_WIDTH;
      height_r    <= sem_pkg::RESET_HEIGHT;
      in_pos_r    <= '0;
      out_pos_r   <= '0;
      feed_col_r  <= '0;
      res_col_r   <= '0;
      res_row_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      state_r    <= state_nxt;
      in_pos_r   <= in_pos_nxt;
      out_pos_r  <= out_pos_nxt;
      feed_col_r <= feed_col_nxt;
      res_col_r  <= res_col_nxt;
      res_row_r  <= res_row_nxt;
      for (int i = 0; i < 9; i++) win_r[i] <= win_nxt[i];
      if (cfg_we && cfg_index == sem_pkg::CFG_IMAGE_WIDTH) width_r <= cfg_data;
      if (cfg_we && cfg_index == sem_pkg::CFG_IMAGE_HEIGHT) height_r <= cfg_data;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      feed_r <= feed_ok;
      pix_r  <= (in_frame && in_ch.command == sem_pkg::CMD_PIXEL)
                ? {in_ch.red_in, in_ch.green_in, in_ch.blue_in} : '0;
    end
    if (load) begin
      red_r   <= lane_edge[0];
      green_r <= lane_edge[1];
      blue_r  <= lane_edge[2];
      last_r  <= last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red_edge   = red_r;
  assign out_ch.green_edge = green_r;
  assign out_ch.blue_edge  = blue_r;
  assign out_ch.frame_last = last_r;

endmodule

// ===== design/sem_checker.sv =====
// Port-level checks for the Sobel edge block, bound to the top level.
// Depends only on the top level's ports.
module sem_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_edge,
  input logic [7:0] green_edge,
  input logic [7:0] blue_edge,
  input logic       frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(red_edge) && $stable(green_edge)
      && $stable(blue_edge) && $stable(frame_last))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous transfer still in work");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .red_edge   (out_ch.red_edge),
  .green_edge (out_ch.green_edge),
  .blue_edge  (out_ch.blue_edge),
  .frame_last (out_ch.frame_last)
);
